// ----- src/three_address_instruction_executor_unit_defines.svh -----
// Assertion macros shared by the three-address instruction executor.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef THREE_ADDRESS_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define THREE_ADDRESS_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAIE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("executor check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define TAIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("executor check failed in the following cycle");

`endif

// ----- src/taie_pkg.sv -----
// Shared types and constants of the three-address instruction executor.
// Used by the controller, the datapath, the divider and the top level; no dependencies.
package taie_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 4;
    localparam int FIRST_W      = 16;
    localparam int THIRD_W      = 4;
    localparam int LEN_W        = 16;
    localparam int OUT_CNT_W    = 16;
    localparam int FAULT_W      = 2;
    localparam int NIBBLE_COUNT = 8;
    localparam int NIB_CNT_W    = 3;

    typedef logic [OP_W-1:0]    opcode_t;
    typedef logic [FAULT_W-1:0] fault_t;

    localparam opcode_t OP_ADD   = 4'd0;
    localparam opcode_t OP_MUL   = 4'd1;
    localparam opcode_t OP_SUB   = 4'd2;
    localparam opcode_t OP_DIV   = 4'd3;
    localparam opcode_t OP_COPY  = 4'd4;
    localparam opcode_t OP_LDI   = 4'd5;
    localparam opcode_t OP_LOAD  = 4'd6;
    localparam opcode_t OP_STORE = 4'd7;
    localparam opcode_t OP_EQ    = 4'd8;
    localparam opcode_t OP_LT    = 4'd9;
    localparam opcode_t OP_LE    = 4'd10;
    localparam opcode_t OP_GT    = 4'd11;
    localparam opcode_t OP_GE    = 4'd12;
    localparam opcode_t OP_JUMP  = 4'd13;
    localparam opcode_t OP_JZ    = 4'd14;

    localparam fault_t FAULT_NONE     = 2'd0;
    localparam fault_t FAULT_DIV_ZERO = 2'd1;
    localparam fault_t FAULT_ADDR     = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_EXEC,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic idx_step;
        logic exec;
        logic div_start;
        logic div_load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_needed;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ----- src/taie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module taie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/taie_divider.sv -----
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on taie_pkg for the data width.
module taie_divider
    import taie_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic signed [DATA_W-1:0] divisor,
    output logic signed [DATA_W-1:0] quotient,
    output logic                     done
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(DATA_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_W-1] ? (DATA_W'(0) - DATA_W'(dividend)) : DATA_W'(dividend);
            dvs_reg <= divisor[DATA_W-1] ? (DATA_W'(0) - DATA_W'(divisor)) : DATA_W'(divisor);
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
            end
            quo_reg <= {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
        end
    end

    // The sign is applied on the way out; the result is registered by the user.
    assign quotient = neg_reg ? $signed(DATA_W'(0) - quo_reg) : $signed(quo_reg);
    assign done     = done_reg;

endmodule

// ----- src/taie_ctrl.sv -----
// Controller state machine of the instruction executor: clearing pass, index
// reduction, execute, divide wait and commit sequencing. Depends on taie_pkg.
module taie_ctrl
    import taie_pkg::*;
#(
    parameter int CLEAR_LEN = 32
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  stat_t                                             stat,
    output cmd_t                                              cmd,
    output logic [((CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1)-1:0] clear_addr
);

    localparam int CLW = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

    state_t               state_reg;
    state_t               state_next;
    logic [CLW-1:0]       clr_cnt_reg;
    logic [CLW-1:0]       clr_cnt_next;
    logic [NIB_CNT_W-1:0] nib_cnt_reg;
    logic [NIB_CNT_W-1:0] nib_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            nib_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            nib_cnt_reg <= nib_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        nib_cnt_next = nib_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLW'(CLEAR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture  = 1'b1;
                    nib_cnt_next = '0;
                    state_next   = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                cmd.idx_step = 1'b1;
                nib_cnt_next = nib_cnt_reg + 1'b1;
                if (nib_cnt_reg == NIB_CNT_W'(NIBBLE_COUNT - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.div_needed)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign clear_addr = clr_cnt_reg;

endmodule

// ----- src/taie_datapath.sv -----
// Datapath of the instruction executor: operand capture, register index reduction,
// register file, data memory, ALU, divider, program counter and output register.
// Depends on taie_pkg, taie_ram and taie_divider.
module taie_datapath
    import taie_pkg::*;
#(
    parameter int REGISTER_COUNT = 16,
    parameter int MEMORY_WORDS   = 32,
    parameter int COUNTER_WIDTH  = 16,
    parameter int CLEAR_LEN      = 32
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  cmd_t                                              cmd,
    output stat_t                                             stat,
    input  logic [((CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1)-1:0] clear_addr,
    input  logic [OP_W-1:0]                                   in_operation,
    input  logic [FIRST_W-1:0]                                in_first,
    input  logic signed [DATA_W-1:0]                          in_second,
    input  logic [THIRD_W-1:0]                                in_third,
    input  logic                                              cfg_wr_en,
    input  logic [LEN_W-1:0]                                  cfg_wr_data,
    input  logic                                              out_ready,
    output logic                                              out_valid,
    output logic [OUT_CNT_W-1:0]                              out_counter,
    output logic signed [DATA_W-1:0]                          out_value,
    output fault_t                                            out_fault,
    output logic                                              out_done
);

    localparam int RW  = $clog2(REGISTER_COUNT);
    localparam int AW  = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam int CLW = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;
    localparam int CW  = COUNTER_WIDTH;

    // One step of x mod REGISTER_COUNT, taken a nibble at a time from the top:
    // (16 * partial + nibble) is below 16 * modulus, so four restoring subtracts finish it.
    function automatic logic [7:0] fold_nibble(input logic [3:0] partial,
                                               input logic [3:0] nib,
                                               input logic [7:0] modulus);
        logic [7:0] t;
        logic [7:0] sub;
        t = {partial, nib};
        for (int k = 3; k >= 0; k--)
        begin
            sub = modulus << k;
            if (t >= sub)
            begin
                t = t - sub;
            end
        end
        return t;
    endfunction

    opcode_t                  op_reg;
    logic [FIRST_W-1:0]       first_reg;
    logic [DATA_W-1:0]        second_reg;
    logic [DATA_W-1:0]        src_a_sh_reg;
    logic [DATA_W-1:0]        src_b_sh_reg;
    logic [DATA_W-1:0]        dst_sh_reg;
    logic [RW-1:0]            src_a_idx_reg;
    logic [RW-1:0]            src_b_idx_reg;
    logic [RW-1:0]            dst_idx_reg;

    logic signed [DATA_W-1:0] rf_a;
    logic signed [DATA_W-1:0] rf_b;
    logic [DATA_W-1:0]        mem_q;

    logic signed [DATA_W-1:0] value_reg;
    fault_t                   fault_reg;
    logic                     wr_rf_reg;
    logic                     wr_mem_reg;
    logic [CW-1:0]            next_pc_reg;
    logic [CW-1:0]            pc_reg;
    logic [LEN_W-1:0]         len_reg;

    logic signed [DATA_W-1:0] value_next;
    fault_t                   fault_next;
    logic                     wr_rf_next;
    logic                     wr_mem_next;
    logic [CW-1:0]            next_pc_next;

    logic                     out_valid_reg;
    logic [OUT_CNT_W-1:0]     out_counter_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    fault_t                   out_fault_reg;
    logic                     out_done_reg;

    logic                     rf_we;
    logic [RW-1:0]            rf_waddr;
    logic [DATA_W-1:0]        rf_wdata;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;

    logic signed [DATA_W-1:0] div_quotient;
    logic                     div_done;

    // Operand capture and index reduction.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= in_operation;
            first_reg     <= in_first;
            second_reg    <= in_second;
            src_a_sh_reg  <= in_second;
            src_b_sh_reg  <= DATA_W'(in_third);
            dst_sh_reg    <= DATA_W'(in_first);
            src_a_idx_reg <= '0;
            src_b_idx_reg <= '0;
            dst_idx_reg   <= '0;
        end
        else if (cmd.idx_step)
        begin
            src_a_sh_reg  <= src_a_sh_reg << 4;
            src_b_sh_reg  <= src_b_sh_reg << 4;
            dst_sh_reg    <= dst_sh_reg << 4;
            src_a_idx_reg <= RW'(fold_nibble(4'(src_a_idx_reg), src_a_sh_reg[DATA_W-1 -: 4],
                                             8'(REGISTER_COUNT)));
            src_b_idx_reg <= RW'(fold_nibble(4'(src_b_idx_reg), src_b_sh_reg[DATA_W-1 -: 4],
                                             8'(REGISTER_COUNT)));
            dst_idx_reg   <= RW'(fold_nibble(4'(dst_idx_reg), dst_sh_reg[DATA_W-1 -: 4],
                                             8'(REGISTER_COUNT)));
        end
    end

    // Register file kept as two copies so both sources read in the same cycle.
    assign rf_we    = (cmd.clear && (32'(clear_addr) < 32'(REGISTER_COUNT)))
                      || (cmd.commit && wr_rf_reg);
    assign rf_waddr = cmd.clear ? RW'(clear_addr) : dst_idx_reg;
    assign rf_wdata = cmd.clear ? '0 : DATA_W'(value_reg);

    taie_ram #(.WIDTH(DATA_W), .DEPTH(REGISTER_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (src_a_idx_reg),
        .rdata (rf_a)
    );

    taie_ram #(.WIDTH(DATA_W), .DEPTH(REGISTER_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (src_b_idx_reg),
        .rdata (rf_b)
    );

    assign mem_we    = (cmd.clear && (32'(clear_addr) < 32'(MEMORY_WORDS)))
                       || (cmd.commit && wr_mem_reg);
    assign mem_waddr = cmd.clear ? AW'(clear_addr) : AW'(first_reg);
    assign mem_wdata = cmd.clear ? '0 : DATA_W'(value_reg);

    taie_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (AW'(second_reg)),
        .rdata (mem_q)
    );

    taie_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rf_a),
        .divisor  (rf_b),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Execute stage.
    always_comb
    begin
        value_next   = '0;
        fault_next   = FAULT_NONE;
        wr_rf_next   = 1'b0;
        wr_mem_next  = 1'b0;
        next_pc_next = pc_reg + 1'b1;
        case (op_reg)
            OP_ADD:
            begin
                value_next = rf_a + rf_b;
                wr_rf_next = 1'b1;
            end
            OP_MUL:
            begin
                value_next = rf_a * rf_b;
                wr_rf_next = 1'b1;
            end
            OP_SUB:
            begin
                value_next = rf_a - rf_b;
                wr_rf_next = 1'b1;
            end
            OP_DIV:
            begin
                // The quotient is loaded once the divider finishes.
                if (rf_b == '0)
                begin
                    fault_next = FAULT_DIV_ZERO;
                end
                else
                begin
                    wr_rf_next = 1'b1;
                end
            end
            OP_COPY:
            begin
                value_next = rf_a;
                wr_rf_next = 1'b1;
            end
            OP_LDI:
            begin
                value_next = $signed(second_reg);
                wr_rf_next = 1'b1;
            end
            OP_LOAD:
            begin
                // A negative address reads as a huge unsigned one and is caught here too.
                if (second_reg >= 32'(MEMORY_WORDS))
                begin
                    fault_next = FAULT_ADDR;
                end
                else
                begin
                    value_next = $signed(mem_q);
                    wr_rf_next = 1'b1;
                end
            end
            OP_STORE:
            begin
                if (32'(first_reg) >= 32'(MEMORY_WORDS))
                begin
                    fault_next = FAULT_ADDR;
                end
                else
                begin
                    value_next  = rf_a;
                    wr_mem_next = 1'b1;
                end
            end
            OP_EQ:
            begin
                value_next = DATA_W'(rf_a == rf_b);
                wr_rf_next = 1'b1;
            end
            OP_LT:
            begin
                value_next = DATA_W'(rf_a < rf_b);
                wr_rf_next = 1'b1;
            end
            OP_LE:
            begin
                value_next = DATA_W'(rf_a <= rf_b);
                wr_rf_next = 1'b1;
            end
            OP_GT:
            begin
                value_next = DATA_W'(rf_a > rf_b);
                wr_rf_next = 1'b1;
            end
            OP_GE:
            begin
                value_next = DATA_W'(rf_a >= rf_b);
                wr_rf_next = 1'b1;
            end
            OP_JUMP:
            begin
                next_pc_next = CW'(first_reg);
            end
            OP_JZ:
            begin
                if (rf_a == '0)
                begin
                    next_pc_next = CW'(first_reg);
                end
            end
            default:
            begin
                value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            value_reg   <= value_next;
            fault_reg   <= fault_next;
            wr_rf_reg   <= wr_rf_next;
            wr_mem_reg  <= wr_mem_next;
            next_pc_reg <= next_pc_next;
        end
        else if (cmd.div_load)
        begin
            value_reg <= div_quotient;
        end
    end

    // Architectural counter, program length and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                pc_reg        <= next_pc_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_counter_reg <= OUT_CNT_W'(next_pc_reg);
            out_value_reg   <= value_reg;
            out_fault_reg   <= fault_reg;
            out_done_reg    <= 32'(next_pc_reg) >= 32'(len_reg);
        end
    end

    assign stat.div_needed = (op_reg == OP_DIV) && (rf_b != '0);
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_counter = out_counter_reg;
    assign out_value   = out_value_reg;
    assign out_fault   = out_fault_reg;
    assign out_done    = out_done_reg;

endmodule

// ----- src/three_address_instruction_executor_unit.sv -----
// Sequence: an instruction is taken in, its register indexes are reduced a nibble at a time,
// the registers are read, the operation executes and the result is committed to the output
// register; a divide with a nonzero divisor first waits for the one-bit-per-cycle divider.
// Throughput: one instruction at a time; a new one is taken only after the last commits.
// Reset: rst_n clears control state; a clearing pass over max(MEMORY_WORDS, REGISTER_COUNT)
// addresses then zeroes the register file and data memory before the first input transfer.
`include "three_address_instruction_executor_unit_defines.svh"

module three_address_instruction_executor_unit
    import taie_pkg::*;
#(
    parameter int REGISTER_COUNT = 16,
    parameter int MEMORY_WORDS   = 32,
    parameter int COUNTER_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // Program length register; written whenever cfg_wr_en is high.
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // Instruction input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: operation[3:0], first_operand[15:0], second_operand[31:0],
    // third_operand[3:0].
    input  logic [55:0] s_axis_tdata,

    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: next_counter[15:0], written_value[31:0].
    output logic [47:0] m_axis_tdata,
    // From bit 0: fault_code[1:0].
    output logic [1:0]  m_axis_tuser,
    // program_done: high when the next counter is at or beyond the program length.
    output logic        m_axis_tlast
);

    // The clearing pass has to cover whichever store is deeper.
    localparam int CLEAR_LEN = (MEMORY_WORDS > REGISTER_COUNT) ? MEMORY_WORDS
                                                                : REGISTER_COUNT;
    localparam int CLW       = (CLEAR_LEN > 1) ? $clog2(CLEAR_LEN) : 1;

    cmd_t                     cmd;
    stat_t                    stat;
    logic [CLW-1:0]           clear_addr;
    logic [OUT_CNT_W-1:0]     out_counter;
    logic signed [DATA_W-1:0] out_value;

    // The controller sequences each instruction through index reduction, register
    // read, execute, an optional divide wait and the final commit. The commit waits
    // only when the output register still holds an untaken result.
    taie_ctrl #(.CLEAR_LEN(CLEAR_LEN)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .stat       (stat),
        .cmd        (cmd),
        .clear_addr (clear_addr)
    );

    // The datapath holds all architectural state: register file, data memory,
    // program counter and program length, plus the output register.
    taie_datapath #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .MEMORY_WORDS   (MEMORY_WORDS),
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .CLEAR_LEN      (CLEAR_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .clear_addr   (clear_addr),
        .in_operation (s_axis_tdata[3:0]),
        .in_first     (s_axis_tdata[19:4]),
        .in_second    (s_axis_tdata[51:20]),
        .in_third     (s_axis_tdata[55:52]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_counter  (out_counter),
        .out_value    (out_value),
        .out_fault    (m_axis_tuser),
        .out_done     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_counter};

    // An accepted instruction always starts index reduction in the next cycle.
    `TAIE_ASSERT_NEXT(a_accept_starts_index, s_axis_tvalid && s_axis_tready, cmd.idx_step)

    // A commit always leaves a valid result in the output register.
    `TAIE_ASSERT_NEXT(a_commit_fills_output, cmd.commit, m_axis_tvalid)

    // A commit never overwrites a result that has not been taken.
    `TAIE_ASSERT_SAME(a_commit_no_overwrite, cmd.commit, !m_axis_tvalid || m_axis_tready)

    // Only the three defined fault codes ever leave the block.
    `TAIE_ASSERT_SAME(a_fault_code_defined, m_axis_tvalid, m_axis_tuser != 2'd3)

endmodule
